### design/ttrb_pkg.sv
// Shared constants, types and the arctangent table of the reach-time estimator.
// Used by every design module but the checker; no dependencies.
package ttrb_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int POS_W        = 15;
   localparam int DIFF_W       = 16;
   localparam int ANG_W        = 16;
   localparam int Z_W          = 24;
   localparam int CX_W         = 27;
   localparam int TIME_W       = 16;
   localparam int RAD_W        = 52;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int NUM_W        = 26;
   localparam int DEN_W        = 16;
   localparam int SUM_W        = NUM_W + 3;

   // pipeline schedule, stage numbers of the top level
   localparam int LAT_CORDIC   = CORDIC_STEPS + 2;
   localparam int S_ANG        = 1 + LAT_CORDIC;
   localparam int S_AMT        = S_ANG + 1;
   localparam int S_DIV_IN     = 4 + ROOT_W;
   localparam int S_Q          = S_DIV_IN + NUM_W;
   localparam int S_SUM        = S_Q + 1;
   localparam int S_OUT        = S_SUM + 1;

   localparam logic [1:0] CSR_FALLEN  = 2'd0;
   localparam logic [1:0] CSR_UNSEEN  = 2'd1;
   localparam logic [1:0] CSR_BONUS   = 2'd2;

   localparam logic [19:0] MS_PER_S_SQ = 20'd1000000;
   localparam logic [9:0]  MS_PER_S    = 10'd1000;
   localparam logic [ANG_W:0] HALF_TURN = (ANG_W+1)'(1 << (ANG_W - 1));
   localparam logic [Z_W-1:0] Z_HALF    = Z_W'(1 << (Z_W - 1));
   localparam logic [Z_W-1:0] Z_ROUND   = Z_W'(1 << (Z_W - ANG_W - 1));

   typedef struct packed {
      logic [ANG_W-1:0] heading;
      logic             fallen;
      logic             seen;
      logic [9:0]       walk_speed;
      logic [DEN_W-1:0] turn_speed;
      logic [DEN_W-1:0] circle_speed;
   } side_type;

   // atan(2^-i) in 2^-24 turn
   function automatic logic [Z_W-1:0] atan_val(input int i);
      logic [Z_W-1:0] v;
      v = '0;
      unique case (i)
         0: v = 24'd2097152;   1: v = 24'd1238021;   2: v = 24'd654136;
         3: v = 24'd332050;    4: v = 24'd166669;    5: v = 24'd83416;
         6: v = 24'd41718;     7: v = 24'd20860;     8: v = 24'd10430;
         9: v = 24'd5215;     10: v = 24'd2608;     11: v = 24'd1304;
        12: v = 24'd652;      13: v = 24'd326;      14: v = 24'd163;
        15: v = 24'd81;       16: v = 24'd41;       17: v = 24'd20;
        18: v = 24'd10;       19: v = 24'd5;        20: v = 24'd3;
        21: v = 24'd1;        22: v = 24'd1;
        default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### design/ttrb_cordic.sv
// Pipelined vectoring CORDIC: direction of (dx, dy) in 2^-16 turn.
// Input, rotation steps and output are all registered; depends on ttrb_pkg.
module ttrb_cordic (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [ttrb_pkg::DIFF_W-1:0] dx,
   input  logic signed [ttrb_pkg::DIFF_W-1:0] dy,
   output logic [ttrb_pkg::ANG_W-1:0]    angle
);
   import ttrb_pkg::*;

   logic signed [CX_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CX_W-1:0] y_ff [0:CORDIC_STEPS];
   logic [Z_W-1:0]         z_ff [0:CORDIC_STEPS];
   logic                   zero_ff [0:CORDIC_STEPS];
   logic [ANG_W-1:0]       ang_ff;
   logic signed [CX_W-1:0] x0_in, y0_in;
   logic [Z_W-1:0]         z0_in, zr;

   // fold the left half plane onto the right one
   always_comb begin
      x0_in = CX_W'(dx) <<< 8;
      y0_in = CX_W'(dy) <<< 8;
      z0_in = '0;
      if (dx < 0) begin
         x0_in = -x0_in;
         y0_in = -y0_in;
         z0_in = Z_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (dx == 0) && (dy == 0);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CX_W-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] < 0) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - atan_val(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + atan_val(i);
            end
         end
      end
   end

   assign zr = z_ff[CORDIC_STEPS] + Z_ROUND;

   // coincident points have direction 0
   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= zero_ff[CORDIC_STEPS] ? '0 : zr[Z_W-1 -: ANG_W];
      end
   end

   assign angle = ang_ff;

endmodule

### design/ttrb_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
// Every stage is registered; depends on ttrb_pkg.
module ttrb_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ttrb_pkg::RAD_W-1:0]    radicand,
   output logic [ttrb_pkg::ROOT_W-1:0]   root
);
   import ttrb_pkg::*;

   localparam int REM_W = ROOT_W + 4;

   logic [REM_W-1:0]  rem_ff  [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W-1];
   logic [RAD_W-1:0]  val_ff  [0:ROOT_W-1];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  p_rem, r2, trial;
      logic [ROOT_W-1:0] p_root;
      logic [RAD_W-1:0]  p_val;
      if (k == 0) begin : g_first
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_val  = radicand;
      end else begin : g_next
         assign p_rem  = rem_ff[k-1];
         assign p_root = root_ff[k-1];
         assign p_val  = val_ff[k-1];
      end
      assign r2    = {p_rem[REM_W-3:0], p_val[RAD_W-1 -: 2]};
      assign trial = {p_root, 2'b01};
      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[k] <= p_val << 2;
            if (r2 >= trial) begin
               rem_ff[k]  <= r2 - trial;
               root_ff[k] <= {p_root[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= r2;
               root_ff[k] <= {p_root[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

### design/ttrb_div.sv
// Pipelined restoring divider, one quotient bit per stage; a zero divisor
// gives an all-ones quotient. Every stage is registered; depends on ttrb_pkg.
module ttrb_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [ttrb_pkg::NUM_W-1:0]   num,
   input  logic [ttrb_pkg::DEN_W-1:0]   den,
   output logic [ttrb_pkg::NUM_W-1:0]   quo
);
   import ttrb_pkg::*;

   logic [DEN_W:0]   rem_ff [0:NUM_W-1];
   logic [NUM_W-1:0] q_ff   [0:NUM_W-1];
   logic [DEN_W-1:0] d_ff   [0:NUM_W-1];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0]   p_rem, r2;
      logic [NUM_W-1:0] p_q;
      logic [DEN_W-1:0] p_d;
      if (k == 0) begin : g_first
         assign p_rem = '0;
         assign p_q   = num;
         assign p_d   = den;
      end else begin : g_next
         assign p_rem = rem_ff[k-1];
         assign p_q   = q_ff[k-1];
         assign p_d   = d_ff[k-1];
      end
      // q carries the remaining numerator bits in and quotient bits out
      assign r2 = {p_rem[DEN_W-1:0], p_q[NUM_W-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k] <= p_d;
            if (r2 >= {1'b0, p_d}) begin
               rem_ff[k] <= r2 - {1'b0, p_d};
               q_ff[k]   <= {p_q[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= r2;
               q_ff[k]   <= {p_q[NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = q_ff[NUM_W-1];

endmodule

### design/time_to_reach_ball_estimate_unit.sv
// Top level of the time-to-reach-ball estimator: input stage, distance and
// angle pipelines, final sum. Uses ttrb_pkg, ttrb_cordic, ttrb_isqrt, ttrb_div.
//
//  channel  | direction | payload
//  req_     | in        | pose, ball, aim, flags, speeds (152 bit tdata)
//  rsp_     | out       | reach_time, striker_reach_time (32 bit tdata)
//  csr_     | in        | register index, 16 bit value
//
// One item per cycle while the output is not stalled; the depth is set by
// the square root and divider stages, one result bit per stage.
// The whole pipeline advances together; it holds only while the output
// register is full and not taken. Reset clears valid bits and the CSR registers.
module time_to_reach_ball_estimate_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // robot_x, robot_y, robot_heading, ball_x, ball_y, aim_x, aim_y,
   // has_fallen, ball_seen_by_self, walk_speed, turn_speed, circle_speed, pad
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // reach_time, striker_reach_time
   output logic [31:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import ttrb_pkg::*;

   logic en;
   logic [TIME_W-1:0] fallen_pen_ff, unseen_pen_ff, bonus_ff;
   logic v_ff [1:S_OUT];
   side_type sb_ff [1:S_Q];
   side_type sb_in;

   logic signed [POS_W-1:0] robot_x, robot_y, ball_x, ball_y, aim_x, aim_y;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, ex_ff, ey_ff;
   logic [31:0] sqx_ff, sqy_ff, d2_ff;
   logic [RAD_W-1:0] m_ff;
   logic [ROOT_W-1:0] root;
   logic [ANG_W-1:0] to_ball, to_aim;
   logic [NUM_W-1:0] amt_t_ff [S_AMT:S_DIV_IN];
   logic [NUM_W-1:0] amt_c_ff [S_AMT:S_DIV_IN];
   logic [NUM_W-1:0] q_dist, q_turn, q_circ;
   logic [SUM_W-1:0] sum_ff;
   logic [TIME_W-1:0] reach_ff, striker_ff, reach_sat;
   logic [ANG_W:0] w_turn, w_circ;

   assign robot_x = req_tdata[14:0];
   assign robot_y = req_tdata[29:15];
   assign ball_x  = req_tdata[60:46];
   assign ball_y  = req_tdata[75:61];
   assign aim_x   = req_tdata[90:76];
   assign aim_y   = req_tdata[105:91];
   assign sb_in   = '{heading: req_tdata[45:30], fallen: req_tdata[106],
                      seen: req_tdata[107], walk_speed: req_tdata[117:108],
                      turn_speed: req_tdata[133:118],
                      circle_speed: req_tdata[149:134]};

   assign en         = !v_ff[S_OUT] || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fallen_pen_ff <= '0;
         unseen_pen_ff <= '0;
         bonus_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FALLEN: fallen_pen_ff <= csr_data;
            CSR_UNSEEN: unseen_pen_ff <= csr_data;
            CSR_BONUS:  bonus_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= S_OUT; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[1] <= req_tvalid;
         for (int i = 2; i <= S_OUT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[1] <= sb_in;
         for (int i = 2; i <= S_Q; i++) sb_ff[i] <= sb_ff[i-1];
         dx_ff <= DIFF_W'(ball_x) - DIFF_W'(robot_x);
         dy_ff <= DIFF_W'(ball_y) - DIFF_W'(robot_y);
         ex_ff <= DIFF_W'(aim_x) - DIFF_W'(ball_x);
         ey_ff <= DIFF_W'(aim_y) - DIFF_W'(ball_y);
         sqx_ff <= 32'(dx_ff * dx_ff);
         sqy_ff <= 32'(dy_ff * dy_ff);
         d2_ff  <= sqx_ff + sqy_ff;
         m_ff   <= RAD_W'(d2_ff * MS_PER_S_SQ);
      end
   end

   ttrb_isqrt u_isqrt (.clock, .en, .radicand(m_ff), .root);

   ttrb_cordic u_dir_ball (.clock, .en, .dx(dx_ff), .dy(dy_ff), .angle(to_ball));
   ttrb_cordic u_dir_aim  (.clock, .en, .dx(ex_ff), .dy(ey_ff), .angle(to_aim));

   // absolute angle differences folded to at most half a turn
   always_comb begin
      w_turn = {1'b0, to_ball - sb_ff[S_ANG].heading};
      w_circ = {1'b0, to_aim - to_ball};
      if (w_turn > HALF_TURN) w_turn = (ANG_W+1)'(2 * HALF_TURN) - w_turn;
      if (w_circ > HALF_TURN) w_circ = (ANG_W+1)'(2 * HALF_TURN) - w_circ;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         amt_t_ff[S_AMT] <= NUM_W'(w_turn * MS_PER_S);
         amt_c_ff[S_AMT] <= NUM_W'(w_circ * MS_PER_S);
         for (int i = S_AMT + 1; i <= S_DIV_IN; i++) begin
            amt_t_ff[i] <= amt_t_ff[i-1];
            amt_c_ff[i] <= amt_c_ff[i-1];
         end
      end
   end

   ttrb_div u_div_dist (.clock, .en, .num(root),
      .den({6'd0, sb_ff[S_DIV_IN].walk_speed}), .quo(q_dist));
   ttrb_div u_div_turn (.clock, .en, .num(amt_t_ff[S_DIV_IN]),
      .den(sb_ff[S_DIV_IN].turn_speed), .quo(q_turn));
   ttrb_div u_div_circ (.clock, .en, .num(amt_c_ff[S_DIV_IN]),
      .den(sb_ff[S_DIV_IN].circle_speed), .quo(q_circ));

   assign reach_sat = (sum_ff > SUM_W'({TIME_W{1'b1}})) ? '1 : sum_ff[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= SUM_W'(q_dist) + SUM_W'(q_turn) + SUM_W'(q_circ)
                 + (sb_ff[S_Q].fallen ? SUM_W'(fallen_pen_ff) : '0)
                 + (sb_ff[S_Q].seen ? '0 : SUM_W'(unseen_pen_ff));
         reach_ff   <= reach_sat;
         striker_ff <= (reach_sat > bonus_ff) ? reach_sat - bonus_ff : '0;
      end
   end

   assign rsp_tvalid = v_ff[S_OUT];
   assign rsp_tdata  = {striker_ff, reach_ff};

endmodule

### design/ttrb_checker.sv
// Port-level checks of the reach-time estimator, bound to the top level.
// Depends only on the top level's ports.
module ttrb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_ready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result present right after reset");

   a_no_block: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while output can move");

   a_striker_le: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] <= rsp_tdata[15:0])
      else $error("striker time above reach time");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_csr: assert property (@(posedge clock) csr_ready)
      else $error("register port not ready");

endmodule

bind time_to_reach_ball_estimate_unit ttrb_checker u_ttrb_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .csr_ready);
